// File: hw/rtl/rcfd_pkg.sv
`timescale 1ns / 1ps

package rcfd_pkg;

   localparam int FRAME_BYTES = 32;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int CHAN_W      = 12;
   localparam int NUM_CHAN    = 6;
   localparam int CHAN_IDX_W  = $clog2(NUM_CHAN);
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [15:0] SUM_INIT      = 16'hffff;
   localparam logic [15:0] SYNC_STAND_IN = 16'd96;
   localparam logic [15:0] SUM_START     = SUM_INIT - SYNC_STAND_IN;

   // byte positions that matter inside a frame
   localparam logic [POS_W-1:0] POS_FIRST_SUM = POS_W'(2);
   localparam logic [POS_W-1:0] POS_LAST_SUM  = POS_W'(FRAME_BYTES - 3);
   localparam logic [POS_W-1:0] POS_FIRST_CH  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_LAST_CH   = POS_W'(13);
   localparam logic [POS_W-1:0] POS_FAILSAFE  = POS_W'(11);
   localparam logic [POS_W-1:0] POS_SUM_LOW   = POS_W'(FRAME_BYTES - 2);
   localparam logic [POS_W-1:0] POS_SUM_HIGH  = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_CH_BASE   = POS_W'(3);

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] right_horizontal;
      logic [CHAN_W-1:0] right_vertical;
      logic [CHAN_W-1:0] left_vertical;
      logic [CHAN_W-1:0] left_horizontal;
      logic [CHAN_W-1:0] switch_a;
      logic [CHAN_W-1:0] switch_c;
      logic [3:0]        failsafe_code;
      logic              failsafe_active;
      logic              checksum_ok;
   } rsp_type;

   // one classified word: data byte and its place in the frame
   typedef struct packed {
      logic [7:0]       data;
      logic [POS_W-1:0] pos;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } push_type;

endpackage

// File: hw/rtl/rc_receiver_frame_decoder_unit.sv
`timescale 1ns / 1ps

// the word for a frame is loaded into the rsp_ register when the back end pops its last byte from the queue
// throughput: one byte per cycle while the queue is not full and rsp_stall does not hold the back end
// a two-word queue between front and back lets each side stall independently
// reset: position goes idle awaiting a start, checksum to its start value,
// channels and fail-safe nibble cleared, queue and output register emptied
module rc_receiver_frame_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rcfd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rcfd_pkg::rsp_type rsp_data
);

   rcfd_pkg::push_type push;
   rcfd_pkg::op_type   head;
   logic               q_empty;
   logic               q_full;
   logic               pop;
   logic               accept;

   // stall only on a full queue; with two entries a steady stream sees it only while rsp_stall holds the back end
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // front: tracks frame position, drops bytes outside a frame
   rcfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push)
   );

   // classified words waiting for the back end
   rcfd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .empty (q_empty),
      .full  (q_full),
      .head  (head)
   );

   // back: checksum, channel capture and the result register
   rcfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hw/rtl/rcfd_front.sv
`timescale 1ns / 1ps

module rcfd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  rcfd_pkg::req_type req_data,
   output rcfd_pkg::push_type push
);

   logic [rcfd_pkg::POS_W:0] pos_ff, pos_in;
   logic                     active;

   assign active = (pos_ff < (rcfd_pkg::POS_W + 1)'(rcfd_pkg::FRAME_BYTES));

   always_comb begin
      pos_in       = pos_ff;
      push.valid   = 1'b0;
      push.op.data = req_data.rx_byte;
      push.op.pos  = pos_ff[rcfd_pkg::POS_W-1:0];
      if (accept) begin
         if (req_data.frame_start) begin
            push.valid  = 1'b1;
            push.op.pos = '0;
            pos_in      = (rcfd_pkg::POS_W + 1)'(1);
         end else if (active) begin
            push.valid = 1'b1;
            pos_in     = pos_ff + (rcfd_pkg::POS_W + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= (rcfd_pkg::POS_W + 1)'(rcfd_pkg::FRAME_BYTES);
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// File: hw/rtl/rcfd_queue.sv
`timescale 1ns / 1ps

module rcfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  rcfd_pkg::push_type push,
   input  logic               pop,
   output logic               empty,
   output logic               full,
   output rcfd_pkg::op_type   head
);

   rcfd_pkg::op_type             mem_ff [rcfd_pkg::QDEPTH];
   logic [rcfd_pkg::QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [rcfd_pkg::QCNT_W-1:0]  count_ff;
   logic                         do_pop;

   assign empty  = (count_ff == '0);
   assign full   = (count_ff == rcfd_pkg::QCNT_W'(rcfd_pkg::QDEPTH));
   assign head   = mem_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + rcfd_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + rcfd_pkg::QPTR_W'(1);
         end
         case ({push.valid, do_pop})
            2'b10:   count_ff <= count_ff + rcfd_pkg::QCNT_W'(1);
            2'b01:   count_ff <= count_ff - rcfd_pkg::QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full && !do_pop))
      else $error("queue written while full");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rcfd_pkg::QCNT_W'(rcfd_pkg::QDEPTH))
      else $error("queue count out of range");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

// File: hw/rtl/rcfd_back.sv
`timescale 1ns / 1ps

module rcfd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  rcfd_pkg::op_type  head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rcfd_pkg::rsp_type rsp_data
);

   logic [15:0]                 sum_ff;
   logic [7:0]                  low_hold_ff;
   logic [7:0]                  sum_low_ff;
   logic [rcfd_pkg::CHAN_W-1:0] chan_ff [rcfd_pkg::NUM_CHAN];
   logic [3:0]                  fs_ff;
   logic                        rsp_valid_ff;
   rcfd_pkg::rsp_type           rsp_data_ff;
   logic [rcfd_pkg::POS_W-1:0]  ch_off;
   logic [rcfd_pkg::CHAN_IDX_W-1:0] ch_idx;
   logic                        in_sum, in_ch, is_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pop       = !q_empty && (!rsp_valid_ff || !rsp_stall);

   assign in_sum  = (head.pos >= rcfd_pkg::POS_FIRST_SUM) && (head.pos <= rcfd_pkg::POS_LAST_SUM);
   assign in_ch   = (head.pos >= rcfd_pkg::POS_FIRST_CH) && (head.pos <= rcfd_pkg::POS_LAST_CH);
   assign is_last = (head.pos == rcfd_pkg::POS_SUM_HIGH);
   assign ch_off  = head.pos - rcfd_pkg::POS_CH_BASE;
   assign ch_idx  = ch_off[rcfd_pkg::CHAN_IDX_W:1];

   // checksum and field capture
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= rcfd_pkg::SUM_START;
         fs_ff  <= '0;
         for (int i = 0; i < rcfd_pkg::NUM_CHAN; i++) begin
            chan_ff[i] <= '0;
         end
      end else if (pop) begin
         if (head.pos == '0) begin
            sum_ff <= rcfd_pkg::SUM_START;
         end else if (in_sum) begin
            sum_ff <= sum_ff - {8'd0, head.data};
         end
         if (in_ch && head.pos[0]) begin
            chan_ff[ch_idx] <= {head.data[3:0], low_hold_ff};
         end
         if (head.pos == rcfd_pkg::POS_FAILSAFE) begin
            fs_ff <= head.data[7:4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (in_ch && !head.pos[0]) begin
            low_hold_ff <= head.data;
         end
         if (head.pos == rcfd_pkg::POS_SUM_LOW) begin
            sum_low_ff <= head.data;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && is_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && is_last) begin
         rsp_data_ff.right_horizontal <= chan_ff[0];
         rsp_data_ff.right_vertical   <= chan_ff[1];
         rsp_data_ff.left_vertical    <= chan_ff[2];
         rsp_data_ff.left_horizontal  <= chan_ff[3];
         rsp_data_ff.switch_a         <= chan_ff[4];
         rsp_data_ff.switch_c         <= chan_ff[5];
         rsp_data_ff.failsafe_code    <= fs_ff;
         rsp_data_ff.failsafe_active  <= (fs_ff != 4'd0);
         rsp_data_ff.checksum_ok      <= (sum_ff == {head.data, sum_low_ff});
      end
   end

`ifndef SYNTHESIS
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (pop && is_last) |=> rsp_valid_ff)
      else $error("final byte did not load a word");
   a_no_pop_blocked: assert property (@(posedge clock) disable iff (reset)
      !(pop && rsp_valid_ff && rsp_stall))
      else $error("queue popped while output blocked");
   a_sum_restart: assert property (@(posedge clock) disable iff (reset)
      (pop && head.pos == '0) |=> (sum_ff == rcfd_pkg::SUM_START))
      else $error("checksum not restarted at frame start");
`endif

endmodule
